// ===== rtl/core/nnt_pkg.sv =====
// Package: shared constants and controller/datapath interface types for the tour builder.
`timescale 1ns / 1ps
`default_nettype none
package nnt_pkg;

  localparam int MAX_NODES = 64;
  localparam int COST_BITS = 32;
  localparam int NODE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 38;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LOAD_W    = ADDR_W + 1;

  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
  localparam logic [SUM_W-1:0]     SUM_MAX  = {SUM_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic init;
    logic base_calc;
    logic scan_issue;
    logic close_add;
    logic commit;
    logic fail;
    logic emit_issue;
  } nnt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic load_last;
    logic scan_end;
    logic found;
    logic tour_done;
    logic emit_end;
  } nnt_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/nearest_neighbour_tour_top.sv =====
// Top level: greedy nearest-neighbour tour builder over a loaded cost matrix.
// Loading takes one cost beat per cycle; busy stays low until the last entry of the n x n matrix.
// After the last entry each of the n-1 greedy steps issues one cost RAM read per column, then
// a read drain and a decide state; an init state comes first, and the closing edge and the
// result readout follow the last step.
// Results then come out one beat per cycle on result_strobe, n beats, or one beat on a dead end.
// Synchronous reset sets node_count to 64, clears the load count and idles the controller.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbour_tour_top import nnt_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire [COST_BITS-1:0]   cost,
  input  wire                   cfg_wen,
  input  wire [CNT_W-1:0]       cfg_wdata,
  output logic                  result_strobe,
  output logic [NODE_W-1:0]     node,
  output logic [SUM_W-1:0]      tour_cost,
  output logic                  last,
  output logic                  failed
);

  nnt_cmd_t  cmd;
  nnt_stat_t stat;

  nnt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  nnt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cost          (cost),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .result_strobe (result_strobe),
    .node          (node),
    .tour_cost     (tour_cost),
    .last          (last),
    .failed        (failed)
  );

endmodule
`default_nettype wire

// ===== rtl/core/nnt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      wen,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/nnt_datapath.sv =====
// Datapath: cost matrix store, greedy scan compare, tour store, sums and result registers.
`timescale 1ns / 1ps
`default_nettype none
module nnt_datapath import nnt_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  input  nnt_cmd_t               cmd,
  output nnt_stat_t              stat,
  input  wire [COST_BITS-1:0]    cost,
  input  wire                    cfg_wen,
  input  wire [CNT_W-1:0]        cfg_wdata,
  output logic                   result_strobe,
  output logic [NODE_W-1:0]      node,
  output logic [SUM_W-1:0]       tour_cost,
  output logic                   last,
  output logic                   failed
);

  logic [CNT_W-1:0]      node_count;
  logic [CNT_W-1:0]      side;
  logic [NODE_W-1:0]     side_m1;
  logic [LOAD_W-1:0]     total;
  logic [LOAD_W-1:0]     load_count;

  logic [ADDR_W-1:0]     base;
  logic [ADDR_W-1:0]     base_next;
  logic [ADDR_W-1:0]     cost_raddr;
  logic [COST_BITS-1:0]  cost_rdata;

  logic [NODE_W-1:0]     scan_idx;
  logic [NODE_W-1:0]     scan_idx_d;
  logic                  rd_valid;
  logic [COST_BITS-1:0]  best;
  logic [NODE_W-1:0]     pick;
  logic                  found;
  logic [MAX_NODES-1:0]  visited;
  logic [NODE_W-1:0]     current;
  logic [NODE_W-1:0]     step;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W:0]        sum_best;
  logic [SUM_W:0]        sum_close;

  logic                  tour_wen;
  logic [NODE_W-1:0]     tour_waddr;
  logic [NODE_W-1:0]     tour_wdata;
  logic [NODE_W-1:0]     emit_idx;
  logic [NODE_W-1:0]     emit_idx_d;
  logic                  emit_valid;
  logic [NODE_W-1:0]     tour_rdata;
  logic                  emit_last;

  // Clamp the node count to the supported range
  always_comb begin
    if (node_count < CNT_W'(2)) begin
      side = CNT_W'(2);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      side = CNT_W'(MAX_NODES);
    end else begin
      side = node_count;
    end
  end

  assign side_m1 = NODE_W'(side - CNT_W'(1));
  assign total   = LOAD_W'(side * side);

  // Hold the node count register and the load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(MAX_NODES);
      load_count <= '0;
    end else if (cfg_wen) begin
      node_count <= cfg_wdata;
      load_count <= '0;
    end else if (cmd.load) begin
      if (stat.load_last) begin
        load_count <= '0;
      end else begin
        load_count <= load_count + LOAD_W'(1);
      end
    end
  end

  // Cost matrix store, read at row base plus column
  assign cost_raddr = base + ADDR_W'(scan_idx);

  nnt_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .wen   (cmd.load),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (cost),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  assign base_next = ADDR_W'(current * side);

  // Scan: row base, column counter and running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
    end
    scan_idx_d <= scan_idx;
    if (cmd.base_calc) begin
      base     <= base_next;
      scan_idx <= '0;
      best     <= COST_MAX;
      pick     <= '0;
      found    <= 1'b0;
    end else begin
      if (cmd.scan_issue) begin
        scan_idx <= scan_idx + NODE_W'(1);
      end
      if (rd_valid && !visited[scan_idx_d] && (cost_rdata < best)) begin
        best  <= cost_rdata;
        pick  <= scan_idx_d;
        found <= 1'b1;
      end
    end
  end

  assign sum_best  = {1'b0, sum} + (SUM_W + 1)'(best);
  assign sum_close = {1'b0, sum} + (SUM_W + 1)'(cost_rdata);

  // Tour state: visited set, current node, step count, saturating sum
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      visited    <= MAX_NODES'(1);
      current    <= '0;
      step       <= NODE_W'(1);
      sum        <= '0;
    end else if (cmd.commit) begin
      visited[pick] <= 1'b1;
      current       <= pick;
      step          <= step + NODE_W'(1);
      sum           <= sum_best[SUM_W] ? SUM_MAX : sum_best[SUM_W-1:0];
    end else if (cmd.close_add) begin
      if (cost_rdata == COST_MAX || sum_close[SUM_W]) begin
        sum <= SUM_MAX;
      end else begin
        sum <= sum_close[SUM_W-1:0];
      end
    end
  end

  // Tour store: node 0 first, then one pick per step
  assign tour_wen   = cmd.init | cmd.commit;
  assign tour_waddr = cmd.init ? '0 : step;
  assign tour_wdata = cmd.init ? '0 : pick;

  nnt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_tour_ram (
    .clk   (clk),
    .wen   (tour_wen),
    .waddr (tour_waddr),
    .wdata (tour_wdata),
    .raddr (emit_idx),
    .rdata (tour_rdata)
  );

  // Advance the emit index and track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid <= 1'b0;
    end else begin
      emit_valid <= cmd.emit_issue;
    end
    emit_idx_d <= emit_idx;
    if (cmd.close_add) begin
      emit_idx <= '0;
    end else if (cmd.emit_issue) begin
      emit_idx <= emit_idx + NODE_W'(1);
    end
  end

  assign emit_last = (emit_idx_d == side_m1);

  // Result registers: one beat per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.fail | emit_valid;
    end
    if (cmd.fail) begin
      node      <= '0;
      tour_cost <= '0;
      last      <= 1'b1;
      failed    <= 1'b1;
    end else begin
      node      <= tour_rdata;
      tour_cost <= emit_last ? sum : '0;
      last      <= emit_last;
      failed    <= 1'b0;
    end
  end

  assign stat.load_last = (load_count == total - LOAD_W'(1));
  assign stat.scan_end  = (scan_idx == side_m1);
  assign stat.found     = found;
  assign stat.tour_done = (step == side_m1);
  assign stat.emit_end  = (emit_idx == side_m1);

endmodule
`default_nettype wire

// ===== rtl/core/nnt_ctrl.sv =====
// Controller: state machine sequencing load, greedy steps, closing edge and result beats.
`timescale 1ns / 1ps
`default_nettype none
module nnt_ctrl import nnt_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  output nnt_cmd_t   cmd,
  input  nnt_stat_t  stat
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_INIT       = 4'd1;
  localparam logic [3:0] S_BASE       = 4'd2;
  localparam logic [3:0] S_SCAN       = 4'd3;
  localparam logic [3:0] S_DRAIN      = 4'd4;
  localparam logic [3:0] S_DECIDE     = 4'd5;
  localparam logic [3:0] S_CLOSE_BASE = 4'd6;
  localparam logic [3:0] S_CLOSE_RD   = 4'd7;
  localparam logic [3:0] S_CLOSE_ADD  = 4'd8;
  localparam logic [3:0] S_EMIT       = 4'd9;
  localparam logic [3:0] S_EMIT_DRAIN = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.load_last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.base_calc = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.found) begin
          cmd.fail   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_next = stat.tour_done ? S_CLOSE_BASE : S_BASE;
        end
      end
      S_CLOSE_BASE: begin
        cmd.base_calc = 1'b1;
        state_next    = S_CLOSE_RD;
      end
      S_CLOSE_RD: begin
        state_next = S_CLOSE_ADD;
      end
      S_CLOSE_ADD: begin
        cmd.close_add = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_issue = 1'b1;
        if (stat.emit_end) begin
          state_next = S_EMIT_DRAIN;
        end
      end
      S_EMIT_DRAIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the nearest-neighbour tour builder: queue-fed driver, predictor and result checker.
`timescale 1ns / 1ps
module tb_top;
  import nnt_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned TAIL_CYCLES   = 80;

  typedef enum logic [1:0] {BEAT_COST, BEAT_CFG, HOLD_DRAIN, GAPS_OFF} feed_kind_e;
  typedef enum logic [1:0] {MIX_WIDE, MIX_NARROW, MIX_SPARSE} cost_mix_e;

  typedef struct {
    feed_kind_e          kind;
    logic [COST_BITS-1:0] data;
  } feed_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [SUM_W-1:0]  total;
    logic              fin;
    logic              dead;
  } tour_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COST_BITS-1:0] cost = '0;
  logic                 cfg_wen = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata = '0;
  logic                 result_strobe;
  logic [NODE_W-1:0]    node;
  logic [SUM_W-1:0]     tour_cost;
  logic                 last;
  logic                 failed;

  nearest_neighbour_tour_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cost         (cost),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .result_strobe(result_strobe),
    .node         (node),
    .tour_cost    (tour_cost),
    .last         (last),
    .failed       (failed)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  feed_t      feed_q[$];
  tour_beat_t tour_expect_q[$];

  // Predictor copy of the block state
  logic [COST_BITS-1:0] matrix_mem [DEPTH];
  logic [CNT_W-1:0]     side_reg = 7'd64;
  int unsigned          load_cnt = 0;
  int unsigned          side_now;

  // Bookkeeping
  int unsigned planned_beats = 0;
  int unsigned accepted_beats = 0;
  int unsigned cfg_writes = 0;
  int unsigned tours_done = 0;
  int unsigned dead_ends = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  logic        beat_took = 1'b0;
  tour_beat_t  want;

  // Driver state
  int unsigned gap_left = 0;
  int unsigned settle_left = 0;
  bit          gaps_on = 1'b1;
  logic        start_next;
  logic        wen_next;
  feed_t       op;

  function automatic int unsigned clamp_side(input logic [CNT_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_NODES) return MAX_NODES;
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [COST_BITS-1:0] b);
    logic [SUM_W:0] wide;
    wide = {1'b0, a} + b;
    return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
  endfunction

  // Greedy tour from node 0 over the loaded matrix; queue the beats it should emit
  task automatic plan_tour(input int unsigned n);
    bit                   seen [MAX_NODES];
    logic [NODE_W-1:0]    order [MAX_NODES];
    int unsigned          here, pick, step, k;
    logic [COST_BITS-1:0] best, closing;
    logic [SUM_W-1:0]     sum;
    bit                   found;
    for (k = 0; k < MAX_NODES; k++) seen[k] = 1'b0;
    seen[0] = 1'b1;
    order[0] = '0;
    here = 0;
    sum = '0;
    for (step = 1; step < n; step++) begin
      best = COST_MAX;
      pick = 0;
      found = 1'b0;
      // strict compare keeps the lowest index on ties
      for (k = 0; k < n; k++) begin
        if (!seen[k] && matrix_mem[here * n + k] < best) begin
          best = matrix_mem[here * n + k];
          pick = k;
          found = 1'b1;
        end
      end
      if (!found) begin
        tour_expect_q.push_back('{node: '0, total: '0, fin: 1'b1, dead: 1'b1});
        return;
      end
      order[step] = pick[NODE_W-1:0];
      seen[pick] = 1'b1;
      sum = sat_sum(sum, best);
      here = pick;
    end
    // closing edge; unreachable return saturates the total
    closing = matrix_mem[here * n];
    sum = (closing == COST_MAX) ? SUM_MAX : sat_sum(sum, closing);
    for (k = 0; k < n; k++) begin
      tour_expect_q.push_back('{node: order[k], total: (k + 1 == n) ? sum : '0,
                                fin: (k + 1 == n), dead: 1'b0});
    end
  endtask

  function automatic logic [COST_BITS-1:0] pick_cost(input cost_mix_e mix);
    case (mix)
      MIX_WIDE:   return ($urandom_range(0, 31) == 0) ? COST_MAX : $urandom;
      MIX_NARROW: return ($urandom_range(0, 7) == 0) ? COST_MAX : $urandom_range(0, 7);
      default: begin
        if ($urandom_range(0, 1)) return COST_MAX;
        return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
      end
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_side_value();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return CNT_W'($urandom_range(7, 9));
      default: return CNT_W'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic push_cost(input logic [COST_BITS-1:0] v);
    feed_q.push_back('{kind: BEAT_COST, data: v});
    planned_beats++;
  endtask

  task automatic push_costs(input int unsigned count, input cost_mix_e mix);
    int unsigned i;
    for (i = 0; i < count; i++) push_cost(pick_cost(mix));
  endtask

  // Let results drain and the block settle, then write node_count
  task automatic push_cfg(input logic [CNT_W-1:0] v);
    feed_q.push_back('{kind: HOLD_DRAIN, data: '0});
    feed_q.push_back('{kind: BEAT_CFG, data: v});
  endtask

  // Drive one beat or register write per step; hold start until the block takes it
  always @(negedge clk) begin
    if (!rst) begin
      start_next = 1'b0;
      wen_next   = 1'b0;
      if (start && !beat_took) begin
        start_next = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (settle_left != 0) begin
        if (tour_expect_q.size() == 0) settle_left--;
      end else if (feed_q.size() != 0) begin
        op = feed_q.pop_front();
        case (op.kind)
          BEAT_COST: begin
            start_next = 1'b1;
            cost <= op.data;
            if (gaps_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
          end
          BEAT_CFG: begin
            wen_next = 1'b1;
            cfg_wdata <= op.data[CNT_W-1:0];
          end
          HOLD_DRAIN: settle_left = SETTLE_CYCLES;
          GAPS_OFF:   gaps_on = 1'b0;
          default: ;
        endcase
      end
      start <= start_next;
      cfg_wen <= wen_next;
    end
  end

  // Check results, track accepted beats and register writes
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end else if (!rst) begin
      beat_took <= start && !busy;
      if (result_strobe) begin
        if (tour_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result node %0d tour_cost %0d last %0b failed %0b",
                   $time, node, tour_cost, last, failed);
        end else begin
          want = tour_expect_q.pop_front();
          if (node !== want.node) begin
            errors++;
            $display("%0t: node expected %0d actual %0d", $time, want.node, node);
          end
          if (tour_cost !== want.total) begin
            errors++;
            $display("%0t: tour_cost expected %0d actual %0d", $time, want.total, tour_cost);
          end
          if (last !== want.fin) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.fin, last);
          end
          if (failed !== want.dead) begin
            errors++;
            $display("%0t: failed expected %0b actual %0b", $time, want.dead, failed);
          end
          if (want.fin && want.dead) dead_ends++;
          else if (want.fin) tours_done++;
        end
      end
      // accepted cost beat: store it and build the tour on the last entry
      if (start && !busy) begin
        accepted_beats++;
        side_now = clamp_side(side_reg);
        if (load_cnt >= side_now * side_now) load_cnt = 0;
        matrix_mem[load_cnt] = cost;
        load_cnt++;
        if (load_cnt == side_now * side_now) begin
          load_cnt = 0;
          plan_tour(side_now);
        end
      end
      // register write restarts loading
      if (cfg_wen) begin
        side_reg = cfg_wdata;
        load_cnt = 0;
        cfg_writes++;
      end
    end
  end

  initial begin
    int unsigned       cur_side, base, pick, i;
    logic [CNT_W-1:0]  side_val;
    cost_mix_e         mix;

    // Partial load at the reset size: no tour may come out
    push_cost('0);
    push_cost(COST_MAX);
    push_cost(32'd1);
    push_cost(32'h8000_0000);
    push_cost(32'h7fff_ffff);
    // Size 0 clamps to 2: plain two-node tour
    push_cfg(7'd0);
    push_cost(COST_MAX); push_cost('0); push_cost(32'd5); push_cost(COST_MAX);
    // Size 1 clamps to 2: only edge out of node 0 unreachable, dead end
    push_cfg(7'd1);
    push_cost('0); push_cost(COST_MAX); push_cost(32'd3); push_cost(32'd9);
    // Largest reachable cost out, unreachable return edge saturates
    push_cfg(7'd2);
    push_cost(32'd1); push_cost(COST_MAX - 1); push_cost(COST_MAX); push_cost(32'd2);
    // Three nodes with a tie on the first step
    push_cfg(7'd3);
    push_cost(32'd9); push_cost(32'd7); push_cost(32'd7);
    push_cost('0); push_cost(COST_MAX); push_cost(32'd3);
    push_cost('0); push_cost(32'd5); push_cost(32'd6);

    // Oversized setting clamps to 64 nodes; partial load, abandoned
    push_cfg(7'd127);
    push_costs(10, MIX_WIDE);
    // Broken load at 64, abandoned by a register write
    push_cfg(7'd64);
    push_costs(10, MIX_WIDE);
    side_val = pick_side_value();
    push_cfg(side_val);
    cur_side = clamp_side(side_val);

    // Random small matrices, some abandoned part way, some resized
    base = planned_beats;
    while (planned_beats - base < 180) begin
      pick = $urandom_range(0, 9);
      mix = cost_mix_e'($urandom_range(0, 2));
      if (pick < 3) begin
        side_val = pick_side_value();
        push_cfg(side_val);
        cur_side = clamp_side(side_val);
      end
      if (pick == 9) begin
        push_costs($urandom_range(1, cur_side * cur_side - 1), mix);
        side_val = pick_side_value();
        push_cfg(side_val);
        cur_side = clamp_side(side_val);
      end else begin
        push_costs(cur_side * cur_side, mix);
        if (pick == 8) feed_q.push_back('{kind: HOLD_DRAIN, data: '0});
      end
    end

    // Closing stretch at full rate on four-node matrices
    push_cfg(7'd4);
    cur_side = 4;
    feed_q.push_back('{kind: GAPS_OFF, data: '0});
    for (i = 0; i < 4; i++) push_costs(cur_side * cur_side, cost_mix_e'(i % 3));

    // Reset held from time zero, released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (feed_q.size() != 0 || accepted_beats != planned_beats || tour_expect_q.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Loaded %0d cost beats over %0d node_count writes, clamped sizes included.",
             accepted_beats, cfg_writes);
    $display("Checked %0d complete tours and %0d dead ends, %0d mismatches.",
             tours_done, dead_ends, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nnt_pkg.sv
rtl/core/nnt_ram.sv
rtl/core/nnt_datapath.sv
rtl/core/nnt_ctrl.sv
rtl/core/nearest_neighbour_tour_top.sv
tb/tb_top.sv
